@@ src/cae_pkg.sv @@
package cae_pkg;

    // fixed field widths
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_W     = 8;
    localparam int LEVEL_W    = 2;
    localparam int AIDX_W     = 3;
    localparam int FILL_W     = 4;
    localparam int DROP_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZER_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK = 3'd4;

    // register reset values
    localparam logic [TIME_W-1:0] CONFIRM_RST     = 32'd3000;
    localparam logic [TIME_W-1:0] BEEP_RST        = 32'd6000;
    localparam logic [TIME_W-1:0] REPEAT_RST      = 32'd60000;
    localparam logic [MASK_W-1:0] BUZZER_MASK_RST = 8'd48;
    localparam logic [MASK_W-1:0] REPEAT_MASK_RST = 8'd64;

    // level an alarm falls back to once cleared
    localparam logic [LEVEL_W-1:0] LEVEL_CLEARED = 2'd1;

    // command field codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_COMMIT = 1'b1;

    typedef struct packed {
        logic [AIDX_W-1:0]  alarm;
        logic [LEVEL_W-1:0] level;
        logic               raised;
    } t_event;

    typedef struct packed {
        logic load;   // capture the input word
        logic pend;   // pending flag update, commit pop
        logic flip;   // confirmed flip or level change, buzzer scan
        logic rpt;    // periodic repeat report
        logic emit;   // load the result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ src/confirmed_alarm_event_engine.sv @@
// Confirmed alarm event engine. Each input word is either an update for one
// alarm (set and clear conditions, a level and the current millisecond time)
// or a commit that pops the head of the event queue. An update runs the
// alarm through hysteresis and a confirm timer, then pushes raise, clear,
// level-change and periodic repeat events into a QUEUE_DEPTH-entry ring; a
// full ring drops the event and counts it in the result. Every word gives
// exactly one result word: queue head, fill, drops of this word and the
// buzzer request. An item is captured, then a three-step sequencer does
// the pending-flag update, the confirmed flip or level change (with the
// buzzer scan over all alarms) and the repeat check, each one 32-bit
// subtract-and-compare deep, then the result register is loaded; no new
// word is taken before that load. While the result register is still full
// and not taken, the engine holds in its last step. Configuration
// registers are written through a plain write port and must only change
// while the engine is idle.
module confirmed_alarm_event_engine #(
    parameter int ALARM_COUNT = 8,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [cae_pkg::AIDX_W-1:0]         i_alarm_index,
    input  logic                               i_set_condition,
    input  logic                               i_clear_condition,
    input  logic [cae_pkg::LEVEL_W-1:0]        i_alarm_level,
    input  logic [cae_pkg::TIME_W-1:0]         i_now_ms,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [cae_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cae_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_event_valid,
    output logic [cae_pkg::AIDX_W-1:0]         o_event_alarm,
    output logic [cae_pkg::LEVEL_W-1:0]        o_event_severity,
    output logic                               o_event_raised,
    output logic [cae_pkg::FILL_W-1:0]         o_queue_fill,
    output logic [cae_pkg::DROP_W-1:0]         o_dropped_events,
    output logic                               o_buzzer_request
);
    import cae_pkg::*;

    // sequencer commands and datapath status
    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // controller: idle, pending update, flip, repeat, result
    cae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // alarm table, event ring, config registers and result register
    cae_datapath #(
        .ALARM_COUNT (ALARM_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_command         (i_command),
        .i_alarm_index     (i_alarm_index),
        .i_set_condition   (i_set_condition),
        .i_clear_condition (i_clear_condition),
        .i_alarm_level     (i_alarm_level),
        .i_now_ms          (i_now_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_event_valid     (o_event_valid),
        .o_event_alarm     (o_event_alarm),
        .o_event_severity  (o_event_severity),
        .o_event_raised    (o_event_raised),
        .o_queue_fill      (o_queue_fill),
        .o_dropped_events  (o_dropped_events),
        .o_buzzer_request  (o_buzzer_request)
    );

    // a captured word keeps the engine busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous word still in work");

    // a result is only loaded into a free result register
    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    // drops only happen against a full ring, and updates never pop
    a_drop_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_dropped_events != '0)) |-> (o_queue_fill == FILL_W'(QUEUE_DEPTH)))
        else $error("event dropped while ring had room");

endmodule

@@ src/cae_ctrl.sv @@
module cae_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cae_pkg::t_dp_status   i_status,
    output cae_pkg::t_ctrl_cmd    o_cmd
);
    import cae_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PEND = 3'd1;
    localparam logic [2:0] ST_FLIP = 3'd2;
    localparam logic [2:0] ST_RPT  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PEND;
                end
            end
            ST_PEND: begin
                o_cmd.pend = 1'b1;
                n_state    = ST_FLIP;
            end
            ST_FLIP: begin
                o_cmd.flip = 1'b1;
                n_state    = ST_RPT;
            end
            ST_RPT: begin
                o_cmd.rpt = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // wait until the result register can take the word
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/cae_datapath.sv @@
module cae_datapath #(
    parameter int ALARM_COUNT = 8,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cae_pkg::t_ctrl_cmd                 i_cmd,
    output cae_pkg::t_dp_status                o_status,
    input  logic                               i_command,
    input  logic [cae_pkg::AIDX_W-1:0]         i_alarm_index,
    input  logic                               i_set_condition,
    input  logic                               i_clear_condition,
    input  logic [cae_pkg::LEVEL_W-1:0]        i_alarm_level,
    input  logic [cae_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                               i_cfg_we,
    input  logic [cae_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cae_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_event_valid,
    output logic [cae_pkg::AIDX_W-1:0]         o_event_alarm,
    output logic [cae_pkg::LEVEL_W-1:0]        o_event_severity,
    output logic                               o_event_raised,
    output logic [cae_pkg::FILL_W-1:0]         o_queue_fill,
    output logic [cae_pkg::DROP_W-1:0]         o_dropped_events,
    output logic                               o_buzzer_request
);
    import cae_pkg::*;

    localparam int AIW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QW:0]   DEPTH_EXT = (QW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
    localparam logic [QW-1:0] HEAD_LAST = QW'(QUEUE_DEPTH - 1);

    // configuration
    logic [TIME_W-1:0] r_confirm;
    logic [TIME_W-1:0] r_beep;
    logic [TIME_W-1:0] r_repeat;
    logic [MASK_W-1:0] r_buzz_mask;
    logic [MASK_W-1:0] r_rpt_mask;

    // captured word
    logic               r_command;
    logic [AIDX_W-1:0]  r_idx;
    logic               r_set;
    logic               r_clr;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_now;
    logic               r_upd;
    logic               r_flip;
    logic               r_buzz;

    // alarm table
    logic               r_pend   [ALARM_COUNT];
    logic               r_active [ALARM_COUNT];
    logic [TIME_W-1:0]  r_since  [ALARM_COUNT];
    logic [LEVEL_W-1:0] r_cur    [ALARM_COUNT];
    logic [LEVEL_W-1:0] r_rep    [ALARM_COUNT];
    logic [TIME_W-1:0]  r_last   [ALARM_COUNT];

    // event ring
    t_event             r_ring [QUEUE_DEPTH];
    logic [QW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [DROP_W-1:0]  r_drops;

    // result register
    logic               r_o_valid;
    logic               r_o_event_valid;
    t_event             r_o_event;
    logic [FILL_W-1:0]  r_o_fill;
    logic [DROP_W-1:0]  r_o_drops;
    logic               r_o_buzz;

    logic [AIW-1:0]     w_a;
    logic               w_act;
    logic               w_pend;
    logic [LEVEL_W-1:0] w_cur;
    logic [LEVEL_W-1:0] w_rep;
    logic               w_desired;
    logic [TIME_W-1:0]  w_since_new;
    logic [TIME_W-1:0]  w_conf_age;
    logic [TIME_W-1:0]  w_rpt_age;
    logic               w_push_flip;
    logic               w_push_rpt;
    t_event             w_flip_ev;
    t_event             w_rpt_ev;
    logic               w_push;
    t_event             w_push_ev;
    logic               w_full;
    logic               w_pop;
    logic [QW:0]        w_tail_sum;
    logic [QW-1:0]      w_tail;
    logic               w_buzz_any;

    always_comb begin
        w_a         = AIW'(r_idx);
        w_act       = r_active[w_a];
        w_pend      = r_pend[w_a];
        w_cur       = r_cur[w_a];
        w_rep       = r_rep[w_a];
        // hysteresis: an active alarm waits for clear, an idle one for set
        w_desired   = w_act ? !r_clr : r_set;
        w_since_new = (w_desired != w_pend) ? r_now : r_since[w_a];
        w_conf_age  = r_now - w_since_new;
        w_rpt_age   = r_now - r_last[w_a];

        w_push_flip      = r_upd && (r_flip || (w_act && (r_level != w_rep)));
        w_flip_ev.alarm  = r_idx;
        w_flip_ev.level  = (r_flip && w_act) ? w_cur : r_level;
        w_flip_ev.raised = !(r_flip && w_act);

        w_push_rpt      = r_upd && w_act && r_rpt_mask[r_idx] && (w_rpt_age >= r_repeat);
        w_rpt_ev.alarm  = r_idx;
        w_rpt_ev.level  = w_cur;
        w_rpt_ev.raised = 1'b1;

        w_push    = (i_cmd.flip && w_push_flip) || (i_cmd.rpt && w_push_rpt);
        w_push_ev = i_cmd.flip ? w_flip_ev : w_rpt_ev;
        w_full    = (r_count == DEPTH_CNT);
        w_pop     = i_cmd.pend && (r_command == CMD_COMMIT) && (r_count != '0);

        w_tail_sum = {1'b0, r_head} + (QW+1)'(r_count);
        w_tail     = (w_tail_sum >= DEPTH_EXT) ? QW'(w_tail_sum - DEPTH_EXT) : QW'(w_tail_sum);

        w_buzz_any = 1'b0;
        for (int i = 0; i < ALARM_COUNT; i++) begin
            if ((i < MASK_W) && r_buzz_mask[i % MASK_W] && r_pend[i] &&
                ((r_now - r_since[i]) >= r_beep)) begin
                w_buzz_any = 1'b1;
            end
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm   <= CONFIRM_RST;
            r_beep      <= BEEP_RST;
            r_repeat    <= REPEAT_RST;
            r_buzz_mask <= BUZZER_MASK_RST;
            r_rpt_mask  <= REPEAT_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CONFIRM:     r_confirm   <= i_cfg_data;
                REG_BEEP:        r_beep      <= i_cfg_data;
                REG_REPEAT:      r_repeat    <= i_cfg_data;
                REG_BUZZER_MASK: r_buzz_mask <= i_cfg_data[MASK_W-1:0];
                REG_REPEAT_MASK: r_rpt_mask  <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // captured word and per-item flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_idx     <= i_alarm_index;
            r_set     <= i_set_condition;
            r_clr     <= i_clear_condition;
            r_level   <= i_alarm_level;
            r_now     <= i_now_ms;
            r_upd     <= (i_command == CMD_UPDATE) && (32'(i_alarm_index) < ALARM_COUNT);
        end
        if (i_cmd.pend) begin
            r_flip <= (w_desired != w_act) && (w_conf_age >= r_confirm);
        end
        if (i_cmd.flip) begin
            r_buzz <= w_buzz_any;
        end
    end

    // alarm table read-modify-write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALARM_COUNT; i++) begin
                r_pend[i]   <= 1'b0;
                r_active[i] <= 1'b0;
                r_since[i]  <= '0;
                r_cur[i]    <= '0;
                r_rep[i]    <= '0;
                r_last[i]   <= '0;
            end
        end else begin
            if (i_cmd.pend && r_upd && (w_desired != w_pend)) begin
                r_pend[w_a]  <= w_desired;
                r_since[w_a] <= r_now;
            end
            if (i_cmd.flip && r_upd) begin
                if (r_flip) begin
                    r_active[w_a] <= !w_act;
                    if (!w_act) begin
                        r_cur[w_a]  <= r_level;
                        r_rep[w_a]  <= r_level;
                        r_last[w_a] <= r_now;
                    end else begin
                        r_cur[w_a] <= LEVEL_CLEARED;
                        r_rep[w_a] <= LEVEL_CLEARED;
                    end
                end else if (w_act && (r_level != w_rep)) begin
                    r_cur[w_a]  <= r_level;
                    r_rep[w_a]  <= r_level;
                    r_last[w_a] <= r_now;
                end
            end
            if (i_cmd.rpt && w_push_rpt) begin
                r_last[w_a] <= r_now;
            end
        end
    end

    // ring pointers and drop count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_drops <= '0;
        end else begin
            if (i_cmd.load) begin
                r_drops <= '0;
            end
            if (w_push) begin
                if (w_full) begin
                    r_drops <= r_drops + 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (w_pop) begin
                r_head  <= (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // ring storage
    always_ff @(posedge i_clk) begin
        if (w_push && !w_full) begin
            r_ring[w_tail] <= w_push_ev;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_event_valid <= (r_count != '0);
            r_o_event       <= (r_count != '0) ? r_ring[r_head] : '0;
            r_o_fill        <= FILL_W'(r_count);
            r_o_drops       <= r_drops;
            r_o_buzz        <= r_buzz;
        end
    end

    assign o_status.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid      = r_o_valid;
    assign o_event_valid    = r_o_event_valid;
    assign o_event_alarm    = r_o_event.alarm;
    assign o_event_severity = r_o_event.level;
    assign o_event_raised   = r_o_event.raised;
    assign o_queue_fill     = r_o_fill;
    assign o_dropped_events = r_o_drops;
    assign o_buzzer_request = r_o_buzz;

endmodule
